FILE: hw/rtl/shs_pkg.sv
// ---------------------------------------------------------------------------
// shs_pkg
// Shared types, sizes and helpers for the Hibbard-gap Shell sort core.
// ---------------------------------------------------------------------------
package shs_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int EXP_W        = $clog2(CNT_W);

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [EXP_W-1:0]         exp_t;

	// Number of gapped passes for a set of n values. The first gap is
	// 2^t - 1, so t is also the exponent of the opening gap.
	function automatic exp_t pass_count(input cnt_t n);
		exp_t lg;
		lg = '0;
		for (int b = 0; b < CNT_W; b++) begin
			if (n[b]) begin
				lg = EXP_W'(b);
			end
		end
		if (n < cnt_t'(4)) begin
			return exp_t'(1);
		end
		return lg - exp_t'(1);
	endfunction

endpackage

FILE: hw/rtl/shell_sort_hibbard_gaps_core.sv
// A set loads at one beat per cycle; the sort then sets up the gap of each pass, fetches each
// element to insert, reads and compares along its chain, and writes the element when it
// reaches the front of its chain. Each value is read from the store and presented, and the
// next one is read only after the previous one was taken.
// Throughput is one set at a time: no input beat is accepted from the last beat of a set
// until its final value has been taken. Reset clears the sequencer, the fill count and the output valid only.
// ---------------------------------------------------------------------------
// shell_sort_hibbard_gaps_core
// Collects a set of signed values and returns them in ascending order using
// a Shell sort over the gap sequence 2^t-1, ..., 7, 3, 1.
// ---------------------------------------------------------------------------
module shell_sort_hibbard_gaps_core
	import shs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [31:0] value,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [31:0] sorted_value,
	output logic              end_of_set
);

	localparam logic [3:0] ST_LOAD    = 4'd0;
	localparam logic [3:0] ST_PASS    = 4'd1;
	localparam logic [3:0] ST_RD_I    = 4'd2;
	localparam logic [3:0] ST_GET_I   = 4'd3;
	localparam logic [3:0] ST_CHK     = 4'd4;
	localparam logic [3:0] ST_CMP     = 4'd5;
	localparam logic [3:0] ST_EM_RD   = 4'd6;
	localparam logic [3:0] ST_EM_LD   = 4'd7;
	localparam logic [3:0] ST_EM_HOLD = 4'd8;

	logic [3:0] state_q;
	cnt_t       count_q;
	cnt_t       n_q;
	exp_t       exp_q;
	cnt_t       gap_q;
	cnt_t       i_q;
	idx_t       j_q;
	idx_t       k_q;
	elem_t      held_q;
	elem_t      rdata_q;
	elem_t      mem_q [MAX_ELEMENTS];

	logic       out_valid_q;
	elem_t      sorted_value_q;
	logic       end_of_set_q;

	logic       in_acc;
	logic       out_acc;
	logic       we;
	idx_t       waddr;
	elem_t      wdata;
	idx_t       raddr;
	logic       j_ge_gap;
	logic       held_less;
	cnt_t       i_next;
	cnt_t       count_next;
	cnt_t       gap_new;

	assign in_stall     = (state_q != ST_LOAD);
	assign in_acc       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign end_of_set   = end_of_set_q;
	assign out_acc      = out_valid_q && !out_stall;

	assign j_ge_gap   = ({1'b0, j_q} >= gap_q);
	assign held_less  = (held_q < rdata_q);
	assign i_next     = i_q + cnt_t'(1);
	assign count_next = (count_q < cnt_t'(MAX_ELEMENTS)) ? count_q + cnt_t'(1) : count_q;
	assign gap_new    = (cnt_t'(1) << exp_q) - cnt_t'(1);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[IDX_W-1:0];
		wdata = value;
		raddr = i_q[IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				we = in_acc && (count_q < cnt_t'(MAX_ELEMENTS));
			end
			ST_CHK: begin
				raddr = j_q - gap_q[IDX_W-1:0];
				if (!j_ge_gap) begin
					we    = 1'b1;
					waddr = j_q;
					wdata = held_q;
				end
			end
			ST_CMP: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = held_less ? rdata_q : held_q;
			end
			ST_EM_RD: begin
				raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	// Element memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						count_q <= count_next;
						if (is_last) begin
							n_q     <= count_next;
							exp_q   <= pass_count(count_next);
							state_q <= ST_PASS;
						end
					end
				end
				ST_PASS: begin
					if (exp_q == '0) begin
						k_q     <= '0;
						state_q <= ST_EM_RD;
					end else begin
						gap_q <= gap_new;
						i_q   <= gap_new;
						exp_q <= exp_q - exp_t'(1);
						// A gap as wide as the set leaves nothing to insert.
						if (gap_new < n_q) begin
							state_q <= ST_RD_I;
						end
					end
				end
				ST_RD_I: begin
					state_q <= ST_GET_I;
				end
				ST_GET_I: begin
					held_q  <= rdata_q;
					j_q     <= i_q[IDX_W-1:0];
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (j_ge_gap) begin
						state_q <= ST_CMP;
					end else begin
						i_q     <= i_next;
						state_q <= (i_next < n_q) ? ST_RD_I : ST_PASS;
					end
				end
				ST_CMP: begin
					if (held_less) begin
						j_q     <= j_q - gap_q[IDX_W-1:0];
						state_q <= ST_CHK;
					end else begin
						i_q     <= i_next;
						state_q <= (i_next < n_q) ? ST_RD_I : ST_PASS;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					out_valid_q    <= 1'b1;
					sorted_value_q <= rdata_q;
					end_of_set_q   <= (cnt_t'(k_q) + cnt_t'(1) == n_q);
					state_q        <= ST_EM_HOLD;
				end
				ST_EM_HOLD: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (end_of_set_q) begin
							count_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + idx_t'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// A result beat is only ever presented while the emit sequence waits for it.
	a_out_only_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_EM_HOLD))
		else $error("result presented outside the emit hold state");

	// The fill count never passes the store depth.
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_ELEMENTS))
		else $error("fill count beyond store depth");

	// The end marker sits on the value read from the last loaded entry.
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_set) |-> (cnt_t'(k_q) + cnt_t'(1) == n_q))
		else $error("end of set flagged on the wrong entry");

	// Taking the final value reopens the block for a fresh set.
	a_reopen_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && end_of_set) |=> (state_q == ST_LOAD && count_q == '0))
		else $error("block did not reopen after the final value");

	// The insertion index never moves above the element being inserted.
	a_j_within_i: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK || state_q == ST_CMP) |-> ({1'b0, j_q} <= i_q))
		else $error("insertion index ran past the inserted element");

endmodule

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Checks the Hibbard-gap Shell sort core. Sets of signed values are loaded
// beat by beat, and every sorted value that comes back is compared with the
// output of an in-bench Shell sort. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb
	import shs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 136;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		elem_t value;
		logic  last;
	} load_beat_t;

	typedef struct {
		elem_t value;
		logic  last;
	} sorted_beat_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	elem_t value = '0;
	logic  is_last = 1'b0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	elem_t sorted_value;
	logic  end_of_set;

	load_beat_t   pending_beats[$];
	sorted_beat_t sorted_due[$];
	elem_t        held_set[MAX_ELEMENTS];
	int           held_count = 0;
	int           failures = 0;
	int           cycle_count = 0;
	int           random_items = 0;
	logic         calm;

	shell_sort_hibbard_gaps_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.end_of_set   (end_of_set)
	);

	always #6 clk = ~clk;

	// A quiet stretch recurs as every third block of the cycle count.
	assign calm = ((cycle_count / 3000) % 3) == 1;

	// Gapped insertion sort over gaps 2^t-1 down to 1, as the core does it.
	function automatic void sort_held_set();
		int    n;
		int    lg;
		int    passes;
		int    gap;
		int    j;
		int    rest;
		elem_t moving;
		n = held_count;
		lg = 0;
		rest = n;
		while (rest > 1) begin
			rest = rest >> 1;
			lg++;
		end
		passes = (n < 4) ? 1 : lg - 1;
		for (int p = 0; p < passes; p++) begin
			gap = (1 << (passes - p)) - 1;
			for (int i = gap; i < n; i++) begin
				moving = held_set[i];
				j = i;
				while (j >= gap && moving < held_set[j - gap]) begin
					held_set[j] = held_set[j - gap];
					j -= gap;
				end
				held_set[j] = moving;
			end
		end
	endfunction

	// Values beyond the store's depth are dropped; the closing beat sorts what is held.
	function automatic void load_element(elem_t v, logic last);
		sorted_beat_t s;
		if (held_count < MAX_ELEMENTS) begin
			held_set[held_count] = v;
			held_count++;
		end
		if (last) begin
			sort_held_set();
			for (int k = 0; k < held_count; k++) begin
				s.value = held_set[k];
				s.last = (k == held_count - 1);
				sorted_due.push_back(s);
			end
			held_count = 0;
		end
	endfunction

	function automatic elem_t pick_value();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: return elem_t'(32'h8000_0000);
					1: return elem_t'(32'h7fff_ffff);
					2: return elem_t'(0);
					3: return elem_t'(-1);
					default: return elem_t'(1);
				endcase
			end
			1: return elem_t'(int'($urandom_range(0, 16)) - 8);
			default: return elem_t'($urandom);
		endcase
	endfunction

	task automatic push_beat(input elem_t v, input logic last);
		load_beat_t b;
		b.value = v;
		b.last = last;
		pending_beats.push_back(b);
	endtask

	task automatic queue_random_set(input int size);
		for (int k = 0; k < size; k++) begin
			push_beat(pick_value(), k == size - 1);
		end
		random_items += size;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Load side: a beat is held until taken, then the next one or an idle cycle follows.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				load_element(value, is_last);
			end
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
					in_valid <= 1'b1;
					value <= pending_beats[0].value;
					is_last <= pending_beats[0].last;
					void'(pending_beats.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: random back-pressure, each taken beat checked against the oldest due.
	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= !calm && ($urandom_range(0, 99) < 16);
			if (out_valid && !out_stall) begin
				if (sorted_due.size() == 0) begin
					$error("sorted beat with none due: sorted_value=%0d end_of_set=%0b",
						sorted_value, end_of_set);
					failures++;
				end else begin
					if (sorted_value !== sorted_due[0].value) begin
						$error("sorted_value: expected %0d, got %0d",
							sorted_due[0].value, sorted_value);
						failures++;
					end
					if (end_of_set !== sorted_due[0].last) begin
						$error("end_of_set: expected %0b, got %0b",
							sorted_due[0].last, end_of_set);
						failures++;
					end
					void'(sorted_due.pop_front());
				end
			end
		end
	end

	initial begin
		// Single-element sets at both extremes, then sets of two and three values.
		push_beat(elem_t'(32'h7fff_ffff), 1'b1);
		push_beat(elem_t'(32'h8000_0000), 1'b1);
		push_beat(elem_t'(32'h7fff_ffff), 1'b0);
		push_beat(elem_t'(32'h8000_0000), 1'b1);
		push_beat(elem_t'(0), 1'b0);
		push_beat(elem_t'(-1), 1'b0);
		push_beat(elem_t'(1), 1'b1);
		// Four values with duplicates: smallest size outside the short-set rule, still one gap-1 pass.
		push_beat(elem_t'(5), 1'b0);
		push_beat(elem_t'(5), 1'b0);
		push_beat(elem_t'(-5), 1'b0);
		push_beat(elem_t'(5), 1'b1);
		for (int k = 0; k < 8; k++) begin
			push_beat(elem_t'(70 - 10 * k), k == 7);
		end
		push_beat(elem_t'(32'h7fff_fffe), 1'b0);
		push_beat(elem_t'(32'h8000_0001), 1'b0);
		push_beat(elem_t'(32'hffff_ffff), 1'b0);
		push_beat(elem_t'(32'h8000_0000), 1'b0);
		push_beat(elem_t'(32'h7fff_ffff), 1'b1);
		// One set runs past the store's depth so the extra values are dropped.
		queue_random_set(MAX_ELEMENTS + 3);
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				queue_random_set($urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 4));
			end else begin
				queue_random_set($urandom_range(1, 12));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_beats.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (sorted_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
